@@ hdl/sess_tbl_pkg.sv @@
`default_nettype none

package sess_tbl_pkg;

    // Field widths of the request and result words.
    localparam int CMD_W        = 3;
    localparam int USER_ID_W    = 32;
    localparam int SESSION_ID_W = 64;
    localparam int TIME_W       = 64;
    localparam int COUNT_W      = 5;

    // Configuration port.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 4;
    localparam logic REG_EXPIRY_SPAN = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_OPEN  = 3'd0,
        CMD_TOUCH = 3'd1,
        CMD_CLOSE = 3'd2,
        CMD_REAP  = 3'd3,
        CMD_QUERY = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_DUP       = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [USER_ID_W-1:0]    user_id;
        logic [SESSION_ID_W-1:0] session_id;
        logic [TIME_W-1:0]       now;
    } req_word_t;

    typedef struct packed {
        status_t            status;
        logic               found;
        logic [COUNT_W-1:0] reaped_count;
        logic [COUNT_W-1:0] active_count;
    } rsp_word_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_last;
    } dp_stat_t;

endpackage

`default_nettype wire

@@ hdl/sess_tbl_ram.sv @@
`default_nettype none

module sess_tbl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                         clk,
    input  wire logic                                         wr_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]     wr_addr,
    input  wire logic [WIDTH-1:0]                             wr_data,
    input  wire logic                                         rd_en,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]     rd_addr,
    output logic [WIDTH-1:0]                                  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/sess_tbl_ctrl.sv @@
`default_nettype none

module sess_tbl_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire sess_tbl_pkg::dp_stat_t  stat,
    output sess_tbl_pkg::ctrl_cmd_t      ctl,
    output logic                         busy
);

    sess_tbl_pkg::state_t state_reg;
    sess_tbl_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sess_tbl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Every command walks the whole table, waits in ST_TAIL for the last read, then commits.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            sess_tbl_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = sess_tbl_pkg::ST_SCAN;
                end
            end
            sess_tbl_pkg::ST_SCAN:
            begin
                ctl.issue = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = sess_tbl_pkg::ST_TAIL;
                end
            end
            sess_tbl_pkg::ST_TAIL:
            begin
                state_next = sess_tbl_pkg::ST_COMMIT;
            end
            sess_tbl_pkg::ST_COMMIT:
            begin
                ctl.commit = 1'b1;
                state_next = sess_tbl_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sess_tbl_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/sess_tbl_dp.sv @@
`default_nettype none

module sess_tbl_dp #(
    parameter int TABLE_ENTRIES    = 16,
    parameter int USER_KEY_BITS    = 32,
    parameter int SESSION_KEY_BITS = 64
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire sess_tbl_pkg::ctrl_cmd_t               ctl,
    output sess_tbl_pkg::dp_stat_t                     stat,
    input  wire sess_tbl_pkg::req_word_t               req,
    input  wire logic [sess_tbl_pkg::TIME_W-1:0]       expiry_span,
    output logic                                       done,
    output sess_tbl_pkg::rsp_word_t                    rsp
);

    localparam int UK_W  = (USER_KEY_BITS < sess_tbl_pkg::USER_ID_W) ?
                           USER_KEY_BITS : sess_tbl_pkg::USER_ID_W;
    localparam int SK_W  = SESSION_KEY_BITS;
    localparam int KEY_W = UK_W + SK_W;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int TW    = sess_tbl_pkg::TIME_W;
    localparam int OCW   = sess_tbl_pkg::COUNT_W;

    // Captured command.
    logic [sess_tbl_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [UK_W-1:0]                uk_reg, uk_next;
    logic [SK_W-1:0]                sk_reg, sk_next;
    logic [TW-1:0]                  now_reg, now_next;

    // Scan pipeline: address issued, then entry evaluated in the next cycle.
    logic [IDX_W-1:0]         addr_reg, addr_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;

    // Table occupancy.
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]         active_reg, active_next;

    // Scan results.
    logic                     dup_reg, dup_next;
    logic                     free_found_reg, free_found_next;
    logic [IDX_W-1:0]         free_idx_reg, free_idx_next;
    logic                     hit_reg, hit_next;
    logic [IDX_W-1:0]         hit_idx_reg, hit_idx_next;
    logic [CNT_W-1:0]         reaped_reg, reaped_next;

    logic                     done_reg, done_next;
    sess_tbl_pkg::rsp_word_t  rsp_reg, rsp_next;

    // Memory ports.
    logic                     key_wr_en;
    logic                     time_wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [KEY_W-1:0]         key_rdata;
    logic [TW-1:0]            time_rdata;

    // Entry compare.
    logic [UK_W-1:0]          ent_user;
    logic [SK_W-1:0]          ent_sess;
    logic                     ent_valid;
    logic                     sess_eq;
    logic                     user_eq;
    logic [TW:0]              age;
    logic                     expired;
    logic [CNT_W+OCW-1:0]     active_ext;
    logic [CNT_W+OCW-1:0]     reaped_ext;

    sess_tbl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (key_wr_en),
        .wr_addr (wr_addr),
        .wr_data ({uk_reg, sk_reg}),
        .rd_en   (ctl.issue),
        .rd_addr (addr_reg),
        .rd_data (key_rdata)
    );

    sess_tbl_ram #(
        .WIDTH (TW),
        .DEPTH (TABLE_ENTRIES)
    ) u_time_ram (
        .clk     (clk),
        .wr_en   (time_wr_en),
        .wr_addr (wr_addr),
        .wr_data (now_reg),
        .rd_en   (ctl.issue),
        .rd_addr (addr_reg),
        .rd_data (time_rdata)
    );

    assign ent_user  = key_rdata[KEY_W-1:SK_W];
    assign ent_sess  = key_rdata[SK_W-1:0];
    assign ent_valid = valid_reg[rd_idx_reg];
    assign sess_eq   = (ent_sess == sk_reg);
    assign user_eq   = (ent_user == uk_reg);

    // The top bit of the difference is the borrow: set when the stamp is ahead of now.
    assign age     = {1'b0, now_reg} - {1'b0, time_rdata};
    assign expired = !age[TW] && (age[TW-1:0] > expiry_span);

    assign stat.scan_last = (addr_reg == IDX_W'(TABLE_ENTRIES - 1));

    assign active_ext = {{OCW{1'b0}}, active_reg};
    assign reaped_ext = {{OCW{1'b0}}, reaped_reg};

    always_comb
    begin
        cmd_next        = cmd_reg;
        uk_next         = uk_reg;
        sk_next         = sk_reg;
        now_next        = now_reg;
        addr_next       = addr_reg;
        rd_vld_next     = ctl.issue;
        rd_idx_next     = addr_reg;
        valid_next      = valid_reg;
        active_next     = active_reg;
        dup_next        = dup_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        reaped_next     = reaped_reg;
        done_next       = ctl.commit;
        rsp_next        = rsp_reg;
        key_wr_en       = 1'b0;
        time_wr_en      = 1'b0;
        wr_addr         = hit_idx_reg;

        if (ctl.load)
        begin
            cmd_next        = req.cmd;
            uk_next         = req.user_id[UK_W-1:0];
            sk_next         = req.session_id[SK_W-1:0];
            now_next        = req.now;
            addr_next       = '0;
            dup_next        = 1'b0;
            free_found_next = 1'b0;
            free_idx_next   = '0;
            hit_next        = 1'b0;
            hit_idx_next    = '0;
            reaped_next     = '0;
        end

        if (ctl.issue)
        begin
            addr_next = addr_reg + IDX_W'(1);
        end

        if (rd_vld_reg)
        begin
            case (cmd_reg) inside
                sess_tbl_pkg::CMD_OPEN:
                begin
                    if (ent_valid && (sess_eq || user_eq))
                    begin
                        dup_next = 1'b1;
                    end
                    if (!ent_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                end
                sess_tbl_pkg::CMD_TOUCH, sess_tbl_pkg::CMD_CLOSE, sess_tbl_pkg::CMD_QUERY:
                begin
                    if (ent_valid && sess_eq && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = rd_idx_reg;
                    end
                end
                sess_tbl_pkg::CMD_REAP:
                begin
                    if (ent_valid && expired)
                    begin
                        valid_next[rd_idx_reg] = 1'b0;
                        active_next            = active_reg - CNT_W'(1);
                        reaped_next            = reaped_reg + CNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (ctl.commit)
        begin
            rsp_next.status       = sess_tbl_pkg::STAT_OK;
            rsp_next.found        = 1'b0;
            rsp_next.reaped_count = '0;
            rsp_next.active_count = '0;
            case (cmd_reg) inside
                sess_tbl_pkg::CMD_OPEN:
                begin
                    wr_addr = free_idx_reg;
                    if (dup_reg)
                    begin
                        rsp_next.status = sess_tbl_pkg::STAT_DUP;
                    end
                    else if (free_found_reg)
                    begin
                        key_wr_en                = 1'b1;
                        time_wr_en               = 1'b1;
                        valid_next[free_idx_reg] = 1'b1;
                        active_next              = active_reg + CNT_W'(1);
                    end
                    else
                    begin
                        rsp_next.status = sess_tbl_pkg::STAT_FULL;
                    end
                end
                sess_tbl_pkg::CMD_TOUCH, sess_tbl_pkg::CMD_CLOSE, sess_tbl_pkg::CMD_QUERY:
                begin
                    if (!hit_reg)
                    begin
                        rsp_next.status = sess_tbl_pkg::STAT_NOT_FOUND;
                    end
                    else
                    begin
                        rsp_next.found = 1'b1;
                        if (cmd_reg == sess_tbl_pkg::CMD_TOUCH)
                        begin
                            time_wr_en = 1'b1;
                        end
                        else if (cmd_reg == sess_tbl_pkg::CMD_CLOSE)
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                            active_next             = active_reg - CNT_W'(1);
                        end
                    end
                end
                sess_tbl_pkg::CMD_REAP:
                begin
                    rsp_next.reaped_count = reaped_ext[OCW-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            valid_reg  <= '0;
            active_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_vld_next;
            valid_reg  <= valid_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        uk_reg         <= uk_next;
        sk_reg         <= sk_next;
        now_reg        <= now_next;
        addr_reg       <= addr_next;
        rd_idx_reg     <= rd_idx_next;
        dup_reg        <= dup_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        reaped_reg     <= reaped_next;
        rsp_reg        <= rsp_next;
    end

    // The active count has settled by the commit edge and is shown with the result.
    always_comb
    begin
        rsp              = rsp_reg;
        rsp.active_count = active_ext[OCW-1:0];
    end

    assign done = done_reg;

endmodule

`default_nettype wire

@@ hdl/session_table_with_idle_aging.sv @@
`default_nettype none

// Session table with idle aging. The block keeps TABLE_ENTRIES sessions, each
// with a user key, a session key and the time of its last activity, and the
// table is empty after reset. A command word is taken when start is high and
// busy is low. Each command then holds busy high while it walks the table
// one entry per cycle through a single read port of the key and time
// memories, waits for the last read and commits. The result word appears
// on result for exactly one cycle, marked by done, in the cycle after the
// commit; the receiver cannot stall it, so it must take the word in that
// cycle. A new command may be started in that same cycle. Open refuses a
// session or user key that is already active, otherwise fills the lowest
// free entry or reports the table full. Touch refreshes the time of a
// session, close frees it, query reports whether it is active. Reap frees
// every entry whose time is not ahead of now and whose idle span exceeds
// expiry_span. Every result carries the number of active entries. The
// expiry_span register is a 64-bit register at byte address 0 of the
// configuration port; the user must write it only while the block is idle,
// and the block itself does not enforce this.
module session_table_with_idle_aging #(
    parameter int TABLE_ENTRIES    = 16,
    parameter int USER_KEY_BITS    = 32,
    parameter int SESSION_KEY_BITS = 64
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,

    // Command channel.
    input  wire logic                                      start,
    output logic                                           busy,
    input  wire sess_tbl_pkg::req_word_t                   request,

    // Result channel.
    output logic                                           done,
    output sess_tbl_pkg::rsp_word_t                        result,

    // Configuration port.
    input  wire logic                                      psel,
    input  wire logic                                      penable,
    input  wire logic                                      pwrite,
    input  wire logic [sess_tbl_pkg::CFG_ADDR_W-1:0]       paddr,
    input  wire logic [sess_tbl_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [sess_tbl_pkg::CFG_DATA_W-1:0]            prdata,
    output logic                                           pready
);

    logic [sess_tbl_pkg::TIME_W-1:0] timeout_reg;
    logic [sess_tbl_pkg::TIME_W-1:0] timeout_next;
    logic                            cfg_wr;
    logic                            reg_sel;

    sess_tbl_pkg::ctrl_cmd_t ctl;
    sess_tbl_pkg::dp_stat_t  stat;

    // The configuration port never waits.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Registers sit on 8-byte boundaries; address bit 3 selects the register.
    assign reg_sel = paddr[3];

    always_comb
    begin
        timeout_next = timeout_reg;
        if (cfg_wr && (reg_sel == sess_tbl_pkg::REG_EXPIRY_SPAN))
        begin
            timeout_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= '0;
        end
        else
        begin
            timeout_reg <= timeout_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            sess_tbl_pkg::REG_EXPIRY_SPAN:
            begin
                prdata = timeout_reg;
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    sess_tbl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    sess_tbl_dp #(
        .TABLE_ENTRIES    (TABLE_ENTRIES),
        .USER_KEY_BITS    (USER_KEY_BITS),
        .SESSION_KEY_BITS (SESSION_KEY_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .stat        (stat),
        .req         (request),
        .expiry_span (timeout_reg),
        .done        (done),
        .rsp         (result)
    );

    // An accepted command always makes the block busy in the next cycle.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a command");

    // A result only follows a cycle in which the block was working.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a command in flight");

    // Each command gives a single one-cycle result strobe.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // A matched session is always reported with an ok status.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.found) |-> (result.status == sess_tbl_pkg::STAT_OK))
        else $error("found set with an error status");

endmodule

`default_nettype wire

@@ sim/session_table_checker.sv @@
`timescale 1ns / 100ps

// Watches the command, result and configuration channels of the session table.
// Every accepted command word is run through a local copy of the table, and
// the result word that it should produce is queued. Each result word that the
// block strobes out is compared with the oldest queued word.
module session_table_checker
    import sess_tbl_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  req_word_t             request,
    input  logic                  done,
    input  rsp_word_t             result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic [CFG_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    errors,
    output int                    outstanding,
    output int                    compared,
    output int                    dup_refusals,
    output int                    full_refusals,
    output int                    sessions_reaped
);

    // The expiry_span register sits at byte address 0 (64-bit registers, 8*i).
    localparam logic [CFG_ADDR_W-1:0] TIMEOUT_ADDR =
        CFG_ADDR_W'(int'(REG_EXPIRY_SPAN) * 8);

    logic                    live          [ENTRIES];
    logic [USER_ID_W-1:0]    owner_user    [ENTRIES];
    logic [SESSION_ID_W-1:0] owner_session [ENTRIES];
    logic [TIME_W-1:0]       last_seen     [ENTRIES];
    logic [TIME_W-1:0]       idle_limit;

    rsp_word_t expected_rsp_q[$];

    // Applies one command word to the local table and returns its result word.
    task automatic predict_session_cmd(input req_word_t word, output rsp_word_t rsp);
        int   slot;
        int   free_slot;
        int   alive;
        logic user_taken;
        slot       = -1;
        free_slot  = -1;
        alive      = 0;
        user_taken = 1'b0;
        rsp        = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (live[i] && owner_session[i] == word.session_id && slot < 0)
                slot = i;
            if (live[i] && owner_user[i] == word.user_id)
                user_taken = 1'b1;
            if (!live[i] && free_slot < 0)
                free_slot = i;
        end
        case (word.cmd)
            CMD_OPEN:
            begin
                if (slot >= 0 || user_taken)
                    rsp.status = STAT_DUP;
                else if (free_slot < 0)
                    rsp.status = STAT_FULL;
                else
                begin
                    live[free_slot]          = 1'b1;
                    owner_user[free_slot]    = word.user_id;
                    owner_session[free_slot] = word.session_id;
                    last_seen[free_slot]     = word.now;
                end
            end
            CMD_TOUCH, CMD_CLOSE, CMD_QUERY:
            begin
                if (slot < 0)
                    rsp.status = STAT_NOT_FOUND;
                else
                begin
                    rsp.found = 1'b1;
                    if (word.cmd == CMD_TOUCH)
                        last_seen[slot] = word.now;
                    else if (word.cmd == CMD_CLOSE)
                        live[slot] = 1'b0;
                end
            end
            CMD_REAP:
            begin
                // A time stamp ahead of now never ages out.
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (live[i] && word.now >= last_seen[i] &&
                        word.now - last_seen[i] > idle_limit)
                    begin
                        live[i] = 1'b0;
                        rsp.reaped_count = rsp.reaped_count + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (live[i])
                alive++;
        end
        rsp.active_count = COUNT_W'(alive);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        rsp_word_t want;
        rsp_word_t next_rsp;
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                live[i]          = 1'b0;
                owner_user[i]    = '0;
                owner_session[i] = '0;
                last_seen[i]     = '0;
            end
            idle_limit = '0;
            expected_rsp_q.delete();
            outstanding     = 0;
            errors          = 0;
            compared        = 0;
            dup_refusals    = 0;
            full_refusals   = 0;
            sessions_reaped = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == TIMEOUT_ADDR)
            begin
                if (pwrite)
                    idle_limit = pwdata;
                else if (prdata !== idle_limit)
                begin
                    errors++;
                    $display("%0t: expiry_span read back expected %0h, got %0h",
                             $realtime, idle_limit, prdata);
                end
            end

            // A result word leaves in the same cycle in which the next command
            // may be taken, so the older expectation is retired first.
            if (done)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with nothing expected, got %p",
                             $realtime, result);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    compared++;
                    if (result.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %s, got %s",
                                 $realtime, want.status.name(), result.status.name());
                    end
                    if (result.found !== want.found)
                    begin
                        errors++;
                        $display("%0t: found expected %b, got %b",
                                 $realtime, want.found, result.found);
                    end
                    if (result.reaped_count !== want.reaped_count)
                    begin
                        errors++;
                        $display("%0t: reaped_count expected %0d, got %0d",
                                 $realtime, want.reaped_count, result.reaped_count);
                    end
                    if (result.active_count !== want.active_count)
                    begin
                        errors++;
                        $display("%0t: active_count expected %0d, got %0d",
                                 $realtime, want.active_count, result.active_count);
                    end
                end
            end

            if (start && !busy)
            begin
                predict_session_cmd(request, next_rsp);
                expected_rsp_q.push_back(next_rsp);
                if (next_rsp.status == STAT_DUP)
                    dup_refusals++;
                if (next_rsp.status == STAT_FULL)
                    full_refusals++;
                sessions_reaped += int'(next_rsp.reaped_count);
            end
            outstanding = expected_rsp_q.size();
        end
    end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

// Top level of the session table testbench. This module only makes stimulus
// and gives the verdict; all prediction and comparison live in the checker
// that sits beside the block and watches the same wires.
//
// The run has a short directed part followed by five random phases. Each
// phase programs a new expiry_span while the table is idle and then sends
// command words drawn mostly from small pools of session and user keys, so
// that duplicates, hits, a full table and reaps all happen often. A running
// clock advances in small steps, now and then jumps backwards, and in one
// phase may wrap through the top of the 64-bit range.
module testbench;
    import sess_tbl_pkg::*;

    localparam int TABLE_ENTRIES = 16;
    localparam int PHASES        = 5;
    localparam int PHASE_WORDS   = 180;
    localparam int SESS_POOL     = 24;
    localparam int USER_POOL     = 20;

    // Command codes 5 to 7 are not operations; the block must ignore them.
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;

    localparam logic [CFG_ADDR_W-1:0] TIMEOUT_ADDR =
        CFG_ADDR_W'(int'(REG_EXPIRY_SPAN) * 8);

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    req_word_t             request;
    logic                  done;
    rsp_word_t             result;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int errors;
    int outstanding;
    int compared;
    int dup_refusals;
    int full_refusals;
    int sessions_reaped;
    int words_sent;
    int settings_used;

    // 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    session_table_with_idle_aging #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    session_table_checker #(
        .ENTRIES(TABLE_ENTRIES)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .request         (request),
        .done            (done),
        .result          (result),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .errors          (errors),
        .outstanding     (outstanding),
        .compared        (compared),
        .dup_refusals    (dup_refusals),
        .full_refusals   (full_refusals),
        .sessions_reaped (sessions_reaped)
    );

    // Presents one command word and returns at the edge that takes it. The
    // sender first waits until the block is idle, then may sit idle for a
    // random number of cycles; each cycle is idle with a chance of idle_pct
    // in a hundred. When no idle cycle is drawn, start simply stays high.
    task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [USER_ID_W-1:0] user,
                            input logic [SESSION_ID_W-1:0] sess, input logic [TIME_W-1:0] stamp,
                            input int idle_pct);
        @(negedge clk);
        while (busy)
            @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start              <= 1'b1;
        request.cmd        <= op;
        request.user_id    <= user;
        request.session_id <= sess;
        request.now        <= stamp;
        do
            @(posedge clk);
        while (busy);
        words_sent++;
    endtask

    // Drops start and holds off until every expected result word has come
    // back. Every command yields exactly one result, so an empty queue means
    // the block is idle.
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Writes expiry_span with a setup and an access cycle, then reads it back
    // the same way so that the checker can compare the read data.
    task automatic program_timeout(input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : stimulus
        logic [SESSION_ID_W-1:0] sess_pool [SESS_POOL];
        logic [USER_ID_W-1:0]    user_pool [USER_POOL];
        logic [CFG_DATA_W-1:0]   phase_timeout [PHASES];
        logic [TIME_W-1:0]       phase_base [PHASES];
        int                      phase_idle [PHASES];
        logic [TIME_W-1:0]       clock;
        logic [TIME_W-1:0]       stamp;
        logic [SESSION_ID_W-1:0] sess;
        logic [USER_ID_W-1:0]    user;
        logic [CMD_W-1:0]        op;
        int                      roll;

        // Every input is known from time zero.
        rst_n      = 1'b0;
        start      = 1'b0;
        request    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        words_sent    = 0;
        settings_used = 0;

        // Key pools include both extremes so that zero and all-ones keys are
        // stored, matched and freed again during the random part.
        sess_pool[0] = '0;
        sess_pool[1] = '1;
        for (int i = 2; i < SESS_POOL; i++)
            sess_pool[i] = {$urandom, $urandom};
        user_pool[0] = '0;
        user_pool[1] = '1;
        for (int i = 2; i < USER_POOL; i++)
            user_pool[i] = $urandom;

        // Idle pattern per phase: none, about half the cycles, none, one in
        // five, none. The receiver cannot stall, so only the sender idles.
        phase_idle = '{0, 49, 0, 20, 0};

        // Timeouts cover a small value, the largest value (nothing can ever
        // age out), zero, a random 64-bit value and a random small value.
        phase_timeout[0] = 64'd30;
        phase_timeout[1] = '1;
        phase_timeout[2] = '0;
        phase_timeout[3] = {$urandom, $urandom};
        phase_timeout[4] = 64'($urandom_range(1, 200));

        // The phase with timeout zero starts just below the top of the time
        // range, so the running clock can wrap through zero during that phase.
        phase_base[0] = '0;
        phase_base[1] = 64'($urandom);
        phase_base[2] = '1 - 64'd800;
        phase_base[3] = {$urandom, $urandom};
        phase_base[4] = 64'd1000;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the reset value of expiry_span (zero).
        // Query and reap on an empty table, then an open and duplicates on each key.
        send_cmd(CMD_QUERY, '0, '0, '0, 0);
        send_cmd(CMD_REAP, '0, '0, '1, 0);
        send_cmd(CMD_OPEN, '0, '0, '0, 0);
        // The session key clashes here while the user key is new.
        send_cmd(CMD_OPEN, '1, '0, '0, 0);
        // And here the user key clashes while the session key is new.
        send_cmd(CMD_OPEN, '0, '1, '0, 0);
        send_cmd(CMD_OPEN, '1, '1, '1, 0);
        send_cmd(CMD_QUERY, '0, '1, '0, 0);
        send_cmd(CMD_TOUCH, '0, '0, 64'd5, 0);
        // Both stored times are ahead of now, so nothing may be reaped even
        // though the timeout is zero.
        send_cmd(CMD_REAP, '0, '0, 64'd3, 0);
        // An unused command code with every other field at all ones.
        send_cmd(CMD_SPARE_FIRST + 3'd2, '1, '1, '1, 0);
        // Fill the rest of the table with times 1 to 14, then overflow it.
        for (int i = 0; i < TABLE_ENTRIES - 2; i++)
            send_cmd(CMD_OPEN, 32'(i + 2), 64'(i + 2), 64'(i + 1), 0);
        send_cmd(CMD_OPEN, 32'd99, 64'd99, '0, 0);
        send_cmd(CMD_CLOSE, '0, '0, '0, 0);
        // Reap at time 10: the entries touched at 1 to 9 age out, the one at
        // 10 has an idle span of zero, and the later ones are ahead of now.
        send_cmd(CMD_REAP, '0, '0, 64'd10, 0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            program_timeout(phase_timeout[phase]);
            clock = phase_base[phase];
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                // Now and then the sender waits for the table to go idle.
                if ($urandom_range(99) < 2)
                    wait_drained();

                roll = $urandom_range(99);
                if (roll < 35)
                    op = CMD_OPEN;
                else if (roll < 55)
                    op = CMD_TOUCH;
                else if (roll < 68)
                    op = CMD_CLOSE;
                else if (roll < 78)
                    op = CMD_REAP;
                else if (roll < 94)
                    op = CMD_QUERY;
                else
                    op = CMD_SPARE_FIRST + CMD_W'($urandom_range(0, 2));

                // Mostly pooled keys, so that lookups hit; sometimes a fresh one.
                sess = ($urandom_range(9) == 0) ? {$urandom, $urandom}
                                                : sess_pool[$urandom_range(SESS_POOL - 1)];
                user = ($urandom_range(9) == 0) ? 32'($urandom)
                                                : user_pool[$urandom_range(USER_POOL - 1)];

                // The clock mostly moves forward, occasionally steps back, and
                // rarely a word carries a wholly random time stamp.
                if ($urandom_range(19) == 0)
                    clock = clock - 64'($urandom_range(1, 60));
                else
                    clock = clock + 64'($urandom_range(0, 12));
                stamp = ($urandom_range(49) == 0) ? {$urandom, $urandom} : clock;

                send_cmd(op, user, sess, stamp, phase_idle[phase]);
            end
        end

        @(negedge clk);
        start <= 1'b0;
        wait_drained();
        repeat (TABLE_ENTRIES + 8) @(negedge clk);

        $display("Sent %0d command words under %0d expiry_span settings; %0d results compared.",
                 words_sent, settings_used + 1, compared);
        $display("Opens refused as duplicate: %0d, as table full: %0d; sessions aged out: %0d.",
                 dup_refusals, full_refusals, sessions_reaped);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Guard against a hung handshake: a correct run needs far less than this.
    initial
    begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/sess_tbl_pkg.sv
hdl/sess_tbl_ram.sv
hdl/sess_tbl_ctrl.sv
hdl/sess_tbl_dp.sv
hdl/session_table_with_idle_aging.sv
sim/session_table_checker.sv
sim/testbench.sv
